[rtl/core/twtd_pkg.sv]
// Shared types, codes and widths for the tree wave termination detector.
package twtd_pkg;

    localparam int ARITY_DEF     = 4;
    localparam int MAX_NODES_DEF = 1024;

    localparam int NODE_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int TOT_W     = 32;
    localparam int KID_W     = 4;
    localparam int BEAT_W    = 3;
    localparam int MAX_BEATS = 5;
    localparam int Q_DEPTH   = 4;

    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_CONTROL  = 3'd1;
    localparam logic [2:0] MODE_RESPONSE = 3'd2;
    localparam logic [2:0] MODE_SEND     = 3'd3;
    localparam logic [2:0] MODE_RECV     = 3'd4;
    localparam logic [2:0] MODE_TERM     = 3'd5;

    localparam logic CFG_NODE_INDEX = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_CONTROL,
        OP_RESPONSE,
        OP_SEND,
        OP_RECV,
        OP_TERM
    } op_t;

    typedef enum logic [1:0] {
        KIND_CONTROL   = 2'd0,
        KIND_RESPONSE  = 2'd1,
        KIND_TERMINATE = 2'd2,
        KIND_DONE      = 2'd3
    } kind_t;

    typedef struct packed {
        op_t              op;
        logic [TOT_W-1:0] child_sent;
        logic [TOT_W-1:0] child_recv;
    } item_t;

    typedef struct packed {
        logic              root;
        logic              single;
        logic [NODE_W-1:0] self;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] first_child;
        logic [KID_W-1:0]  nkids;
    } topo_t;

endpackage

[rtl/core/twtd_front.sv]
// Front end: accepts input beats and classifies them into operations.
module twtd_front
    import twtd_pkg::*;
(
    input  logic             in_valid,
    input  logic [2:0]       mode,
    input  logic [TOT_W-1:0] child_sent,
    input  logic [TOT_W-1:0] child_recv,
    input  logic             q_full,
    output logic             in_stall,
    output logic             push,
    output item_t            push_item
);

    op_t op;

    always_comb
    begin
        unique case (mode)
            MODE_START:    op = OP_START;
            MODE_CONTROL:  op = OP_CONTROL;
            MODE_RESPONSE: op = OP_RESPONSE;
            MODE_SEND:     op = OP_SEND;
            MODE_RECV:     op = OP_RECV;
            MODE_TERM:     op = OP_TERM;
            default:       op = OP_NONE;
        endcase
    end

    // drop unused modes here, they cause nothing
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full && (op != OP_NONE);
    assign push_item = item_t'{op: op, child_sent: child_sent, child_recv: child_recv};

endmodule

[rtl/core/twtd_queue.sv]
// Short FIFO of classified operations between front and back.
module twtd_queue
    import twtd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  valid,
    output item_t head
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W  = $clog2(Q_DEPTH + 1);

    item_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QC_W'(1);
            2'b01:   count_next = count_reg - QC_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full  = (count_reg == QC_W'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");

endmodule

[rtl/core/twtd_topo.sv]
// Configuration registers and derived tree position (parent, children).
module twtd_topo
    import twtd_pkg::*;
#(
    parameter int ARITY     = ARITY_DEF,
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data,
    output logic               cfg_ready,
    output topo_t              topo
);

    localparam int FC_W        = NODE_W + $clog2(ARITY + 1);
    localparam int CAP         = (MAX_NODES < (2**COUNT_W - 1)) ? MAX_NODES : (2**COUNT_W - 1);
    localparam int RECIP_SHIFT = 2 * NODE_W;
    localparam int RECIP       = (2**RECIP_SHIFT + ARITY - 1) / ARITY;
    localparam int PROD_W      = 3 * NODE_W;

    logic [NODE_W-1:0]  node_index_reg, node_index_next;
    logic [COUNT_W-1:0] node_count_reg, node_count_next;
    topo_t              topo_reg, topo_next;

    logic [COUNT_W-1:0] eff;
    logic [FC_W-1:0]    fc_full;
    logic [FC_W-1:0]    eff_w;
    logic [FC_W-1:0]    spare;
    logic [NODE_W-1:0]  idx_m1;
    logic [PROD_W-1:0]  prod;

    always_comb
    begin
        node_index_next = node_index_reg;
        node_count_next = node_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NODE_INDEX: node_index_next = cfg_data[NODE_W-1:0];
                CFG_NODE_COUNT: node_count_next = cfg_data;
                default:        node_count_next = node_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (node_count_reg == '0)
            eff = COUNT_W'(1);
        else if (node_count_reg > COUNT_W'(CAP))
            eff = COUNT_W'(CAP);
        else
            eff = node_count_reg;

        fc_full = FC_W'(node_index_reg) * FC_W'(ARITY) + FC_W'(1);
        eff_w   = FC_W'(eff);
        spare   = (eff_w > fc_full) ? (eff_w - fc_full) : '0;

        // parent by reciprocal multiply, exact for every 10-bit index
        idx_m1 = node_index_reg - NODE_W'(1);
        prod   = PROD_W'(idx_m1) * PROD_W'(RECIP);

        topo_next.root        = (node_index_reg == '0);
        topo_next.single      = (eff == COUNT_W'(1));
        topo_next.self        = node_index_reg;
        topo_next.parent      = prod[RECIP_SHIFT +: NODE_W];
        topo_next.first_child = fc_full[NODE_W-1:0];
        topo_next.nkids       = (spare > FC_W'(ARITY)) ? KID_W'(ARITY) : spare[KID_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_index_reg       <= '0;
            node_count_reg       <= COUNT_W'(1);
            topo_reg.root        <= 1'b1;
            topo_reg.single      <= 1'b1;
            topo_reg.self        <= '0;
            topo_reg.parent      <= '0;
            topo_reg.first_child <= NODE_W'(1);
            topo_reg.nkids       <= '0;
        end
        else
        begin
            node_index_reg <= node_index_next;
            node_count_reg <= node_count_next;
            topo_reg       <= topo_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign topo      = topo_reg;

    a_kids_bound: assert property (@(posedge clk) disable iff (!rst_n)
        topo_reg.nkids <= KID_W'(ARITY))
        else $error("child count above arity");

    a_single_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        topo_reg.single |-> (topo_reg.nkids == '0))
        else $error("single node with children");

endmodule

[rtl/core/twtd_back.sv]
// Back end: counters, wave accounting and burst sequencer with output register.
module twtd_back
    import twtd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  topo_t             topo,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              pop,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [1:0]        kind,
    output logic [NODE_W-1:0] dest_node,
    output logic [TOT_W-1:0]  total_sent,
    output logic [TOT_W-1:0]  total_recv,
    output logic              last
);

    localparam int KN_W = KID_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BURST
    } state_t;

    typedef enum logic [1:0] {
        LOAD_NONE,
        LOAD_CTL,
        LOAD_TERM,
        LOAD_RESP
    } load_t;

    state_t             state_reg, state_next;
    logic [TOT_W-1:0]   local_sent_reg, local_sent_next;
    logic [TOT_W-1:0]   local_recv_reg, local_recv_next;
    logic [TOT_W-1:0]   wave_sent_reg, wave_sent_next;
    logic [TOT_W-1:0]   wave_recv_reg, wave_recv_next;
    logic [TOT_W-1:0]   prior_sent_reg, prior_sent_next;
    logic [TOT_W-1:0]   prior_recv_reg, prior_recv_next;
    logic [KID_W-1:0]   pend_reg, pend_next;
    logic               done_reg, done_next;

    logic               head_reg, head_next;
    kind_t              head_kind_reg, head_kind_next;
    logic [NODE_W-1:0]  head_dest_reg, head_dest_next;
    logic [TOT_W-1:0]   head_sent_reg, head_sent_next;
    logic [TOT_W-1:0]   head_recv_reg, head_recv_next;
    kind_t              kid_kind_reg, kid_kind_next;
    logic [NODE_W-1:0]  kid_dest_reg, kid_dest_next;
    logic [BEAT_W-1:0]  beats_reg, beats_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [NODE_W-1:0]  dest_reg, dest_next;
    logic [TOT_W-1:0]   sent_out_reg, sent_out_next;
    logic [TOT_W-1:0]   recv_out_reg, recv_out_next;
    logic               last_reg, last_next;

    load_t              sel;
    logic [TOT_W-1:0]   ws, wr;
    logic [TOT_W-1:0]   resp_sent, resp_recv;
    logic               hit;
    logic [BEAT_W-1:0]  ctl_beats, term_beats;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? '1 : s[TOT_W-1:0];
    endfunction

    function automatic logic [BEAT_W-1:0] cap_beats(input logic [KN_W-1:0] n);
        return (n > KN_W'(MAX_BEATS)) ? BEAT_W'(MAX_BEATS) : n[BEAT_W-1:0];
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        local_sent_next = local_sent_reg;
        local_recv_next = local_recv_reg;
        wave_sent_next  = wave_sent_reg;
        wave_recv_next  = wave_recv_reg;
        prior_sent_next = prior_sent_reg;
        prior_recv_next = prior_recv_reg;
        pend_next       = pend_reg;
        done_next       = done_reg;
        head_next       = head_reg;
        head_kind_next  = head_kind_reg;
        head_dest_next  = head_dest_reg;
        head_sent_next  = head_sent_reg;
        head_recv_next  = head_recv_reg;
        kid_kind_next   = kid_kind_reg;
        kid_dest_next   = kid_dest_reg;
        beats_next      = beats_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        dest_next       = dest_reg;
        sent_out_next   = sent_out_reg;
        recv_out_next   = recv_out_reg;
        last_next       = last_reg;
        pop             = 1'b0;
        sel             = LOAD_NONE;
        resp_sent       = local_sent_reg;
        resp_recv       = local_recv_reg;

        ws         = sat_add(wave_sent_reg, local_sent_reg);
        wr         = sat_add(wave_recv_reg, local_recv_reg);
        hit        = (ws == wr) && (prior_sent_reg == prior_recv_reg) &&
                     (ws == prior_sent_reg) && (ws != '0);
        ctl_beats  = cap_beats({1'b0, topo.nkids});
        term_beats = cap_beats({1'b0, topo.nkids} + KN_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (q_item.op)
                        OP_START:
                        begin
                            if (topo.root)
                            begin
                                pend_next = topo.nkids;
                                if (topo.single)
                                    state_next = ST_CHECK;
                                else
                                    sel = LOAD_CTL;
                            end
                        end
                        OP_CONTROL:
                        begin
                            if (topo.nkids != '0)
                            begin
                                pend_next = topo.nkids;
                                sel       = LOAD_CTL;
                            end
                            else if (!topo.root)
                            begin
                                pend_next = '0;
                                sel       = LOAD_RESP;
                            end
                        end
                        OP_RESPONSE:
                        begin
                            if (pend_reg != '0)
                            begin
                                wave_sent_next = sat_add(wave_sent_reg, q_item.child_sent);
                                wave_recv_next = sat_add(wave_recv_reg, q_item.child_recv);
                                pend_next      = pend_reg - KID_W'(1);
                                if (pend_reg == KID_W'(1))
                                    state_next = ST_CHECK;
                            end
                        end
                        OP_SEND:
                        begin
                            if (!done_reg)
                                local_sent_next = sat_add(local_sent_reg, TOT_W'(1));
                        end
                        OP_RECV:
                        begin
                            if (!done_reg)
                                local_recv_next = sat_add(local_recv_reg, TOT_W'(1));
                        end
                        OP_TERM:
                        begin
                            done_next = 1'b1;
                            sel       = LOAD_TERM;
                        end
                        OP_NONE:
                        begin
                            pop = 1'b1;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                state_next = ST_IDLE;
                if (topo.root)
                begin
                    if (hit)
                    begin
                        done_next      = 1'b1;
                        wave_sent_next = ws;
                        wave_recv_next = wr;
                        sel            = LOAD_TERM;
                    end
                    else
                    begin
                        prior_sent_next = ws;
                        prior_recv_next = wr;
                        wave_sent_next  = '0;
                        wave_recv_next  = '0;
                        if (!topo.single)
                        begin
                            pend_next = topo.nkids;
                            sel       = LOAD_CTL;
                        end
                    end
                end
                else
                begin
                    resp_sent      = ws;
                    resp_recv      = wr;
                    wave_sent_next = '0;
                    wave_recv_next = '0;
                    pend_next      = topo.nkids;
                    sel            = LOAD_RESP;
                end
            end
            ST_BURST:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (head_reg)
                    begin
                        kind_next     = head_kind_reg;
                        dest_next     = head_dest_reg;
                        sent_out_next = head_sent_reg;
                        recv_out_next = head_recv_reg;
                        head_next     = 1'b0;
                    end
                    else
                    begin
                        kind_next     = kid_kind_reg;
                        dest_next     = kid_dest_reg;
                        sent_out_next = '0;
                        recv_out_next = '0;
                        kid_dest_next = kid_dest_reg + NODE_W'(1);
                    end
                    last_next  = (beats_reg == BEAT_W'(1));
                    beats_next = beats_reg - BEAT_W'(1);
                    if (beats_reg == BEAT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        unique case (sel)
            LOAD_CTL:
            begin
                head_next     = 1'b0;
                kid_kind_next = KIND_CONTROL;
                kid_dest_next = topo.first_child;
                beats_next    = ctl_beats;
            end
            LOAD_TERM:
            begin
                head_next      = 1'b1;
                head_kind_next = KIND_DONE;
                head_dest_next = topo.self;
                head_sent_next = '0;
                head_recv_next = '0;
                kid_kind_next  = KIND_TERMINATE;
                kid_dest_next  = topo.first_child;
                beats_next     = term_beats;
            end
            LOAD_RESP:
            begin
                head_next      = 1'b1;
                head_kind_next = KIND_RESPONSE;
                head_dest_next = topo.parent;
                head_sent_next = resp_sent;
                head_recv_next = resp_recv;
                beats_next     = BEAT_W'(1);
            end
            default:
            begin
                beats_next = beats_next;
            end
        endcase

        if (sel != LOAD_NONE)
            state_next = (beats_next != '0) ? ST_BURST : ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            local_sent_reg <= '0;
            local_recv_reg <= '0;
            wave_sent_reg  <= '0;
            wave_recv_reg  <= '0;
            prior_sent_reg <= '0;
            prior_recv_reg <= '0;
            pend_reg       <= '0;
            done_reg       <= 1'b0;
            head_reg       <= 1'b0;
            head_kind_reg  <= KIND_CONTROL;
            head_dest_reg  <= '0;
            head_sent_reg  <= '0;
            head_recv_reg  <= '0;
            kid_kind_reg   <= KIND_CONTROL;
            kid_dest_reg   <= '0;
            beats_reg      <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_CONTROL;
            dest_reg       <= '0;
            sent_out_reg   <= '0;
            recv_out_reg   <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            local_sent_reg <= local_sent_next;
            local_recv_reg <= local_recv_next;
            wave_sent_reg  <= wave_sent_next;
            wave_recv_reg  <= wave_recv_next;
            prior_sent_reg <= prior_sent_next;
            prior_recv_reg <= prior_recv_next;
            pend_reg       <= pend_next;
            done_reg       <= done_next;
            head_reg       <= head_next;
            head_kind_reg  <= head_kind_next;
            head_dest_reg  <= head_dest_next;
            head_sent_reg  <= head_sent_next;
            head_recv_reg  <= head_recv_next;
            kid_kind_reg   <= kid_kind_next;
            kid_dest_reg   <= kid_dest_next;
            beats_reg      <= beats_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            dest_reg       <= dest_next;
            sent_out_reg   <= sent_out_next;
            recv_out_reg   <= recv_out_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign dest_node  = dest_reg;
    assign total_sent = sent_out_reg;
    assign total_recv = recv_out_reg;
    assign last       = last_reg;

    a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BURST) |-> (beats_reg != '0))
        else $error("burst with no beats left");

    a_check_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (pend_reg == '0))
        else $error("wave check with responses outstanding");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("terminated flag cleared");

endmodule

[rtl/core/tree_wave_termination_detector_core.sv]
// Top level of one node of the tree wave termination detector.
// Path: a result beat passes the queue, the back end sequencer and the output register;
// a beat that closes a wave also passes the wave check on the last child response.
// Throughput: one input beat per cycle for counting notices unless in_stall is high;
// an item with results holds the back end while its result beats go out and during a wave check.
// Reset: rst_n clears all counters, the terminated flag, the queue and the output register.
module tree_wave_termination_detector_core
    import twtd_pkg::*;
#(
    parameter int ARITY     = ARITY_DEF,
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic [TOT_W-1:0]   child_sent,
    input  logic [TOT_W-1:0]   child_recv,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [NODE_W-1:0]  dest_node,
    output logic [TOT_W-1:0]   total_sent,
    output logic [TOT_W-1:0]   total_recv,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t q_item;
    topo_t topo;

    twtd_topo #(
        .ARITY     (ARITY),
        .MAX_NODES (MAX_NODES)
    ) u_topo (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .topo      (topo)
    );

    twtd_front u_front (
        .in_valid   (in_valid),
        .mode       (mode),
        .child_sent (child_sent),
        .child_recv (child_recv),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_item  (push_item)
    );

    twtd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_item)
    );

    twtd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .topo       (topo),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .kind       (kind),
        .dest_node  (dest_node),
        .total_sent (total_sent),
        .total_recv (total_recv),
        .last       (last)
    );

endmodule
